/* hdl/ppmsp_pkg.sv */
package ppmsp_pkg;

  localparam int VALUE_BITS_DEF = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
    logic        bad_char;
  } result_item_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXCOL,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  // sequencer to tokenizer
  typedef struct packed {
    logic step;
    logic clear;
    logic err_clr;
  } tok_ctl_t;

  // tokenizer to sequencer
  typedef struct packed {
    logic done;
    logic err;
  } tok_evt_t;

endpackage

/* hdl/ppmsp_tok.sv */
module ppmsp_tok import ppmsp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tok_ctl_t              ctl,
  input  logic [7:0]            data_byte,
  output tok_evt_t              evt,
  output logic [VALUE_BITS-1:0] value
);

  localparam int PW = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  logic                  in_token, in_token_next;
  logic                  in_comment, in_comment_next;
  logic [VALUE_BITS-1:0] accum, accum_next;
  logic                  error_seen, error_seen_next;

  logic          is_sep;
  logic          is_digit;
  logic [7:0]    dsub;
  logic [PW-1:0] acc_ext;
  logic [PW-1:0] prod;

  assign is_sep   = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_NL);
  assign is_digit = data_byte inside {[CH_ZERO:CH_NINE]};
  assign dsub     = data_byte - CH_ZERO;
  assign acc_ext  = {4'd0, accum};
  // accum * 10 + digit as two shifts and two adds
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{(PW-4){1'b0}}, dsub[3:0]};

  always_comb begin
    in_token_next   = in_token;
    in_comment_next = in_comment;
    accum_next      = accum;
    error_seen_next = error_seen;
    evt.done        = 1'b0;
    evt.err         = error_seen;
    if (ctl.clear) begin
      in_token_next   = 1'b0;
      in_comment_next = 1'b0;
      accum_next      = '0;
      error_seen_next = 1'b0;
    end else if (ctl.step) begin
      if (in_comment) begin
        if (data_byte == CH_NL) begin
          in_comment_next = 1'b0;
        end
      end else if (is_sep) begin
        if (in_token) begin
          in_token_next = 1'b0;
          accum_next    = '0;
          evt.done      = 1'b1;
        end
      end else if (!in_token && data_byte == CH_HASH) begin
        in_comment_next = 1'b1;
      end else begin
        in_token_next = 1'b1;
        if (is_digit) begin
          if (prod > {4'd0, VMAX}) begin
            accum_next      = VMAX;
            error_seen_next = 1'b1;
          end else begin
            accum_next = prod[VALUE_BITS-1:0];
          end
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end
    if (ctl.err_clr) begin
      error_seen_next = 1'b0;
    end
  end

  assign value   = accum;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token   <= 1'b0;
      in_comment <= 1'b0;
      accum      <= '0;
      error_seen <= 1'b0;
    end else begin
      in_token   <= in_token_next;
      in_comment <= in_comment_next;
      accum      <= accum_next;
      error_seen <= error_seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a comment never starts inside a token
  assert property (@(posedge clk) disable iff (rst) !(in_token && in_comment))
    else $error("token and comment active together");
`endif

endmodule

/* hdl/ppmsp_seq.sv */
module ppmsp_seq import ppmsp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  byte_item_t            item,
  input  tok_evt_t              evt,
  input  logic [VALUE_BITS-1:0] value,
  output tok_ctl_t              ctl,
  output logic                  push,
  output result_item_t          result
);

  function automatic logic [15:0] fit16(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS+15:0] w;
    w = {16'd0, v};
    return w[15:0];
  endfunction

  phase_t                phase, phase_next;
  logic [1:0]            component, component_next;
  logic [VALUE_BITS-1:0] held_red, held_red_next;
  logic [VALUE_BITS-1:0] held_green, held_green_next;
  logic [VALUE_BITS-1:0] image_width, image_width_next;
  logic [VALUE_BITS-1:0] image_height, image_height_next;
  logic [VALUE_BITS-1:0] cur_col, cur_col_next;
  logic [VALUE_BITS-1:0] cur_row, cur_row_next;

  logic              active;
  logic [VALUE_BITS:0] col_p1;
  logic [VALUE_BITS:0] row_p1;
  logic              col_end;
  logic              row_end;
  logic              empty_img;

  assign active    = phase inside {PH_WIDTH, PH_HEIGHT, PH_MAXCOL, PH_PIXELS};
  assign col_p1    = {1'b0, cur_col} + {{VALUE_BITS{1'b0}}, 1'b1};
  assign row_p1    = {1'b0, cur_row} + {{VALUE_BITS{1'b0}}, 1'b1};
  assign col_end   = col_p1 >= {1'b0, image_width};
  assign row_end   = row_p1 >= {1'b0, image_height};
  assign empty_img = (image_width == '0) || (image_height == '0);

  assign ctl.step    = accept && !item.start_req && active;
  assign ctl.clear   = accept && item.start_req;
  assign ctl.err_clr = push;

  always_comb begin
    phase_next        = phase;
    component_next    = component;
    held_red_next     = held_red;
    held_green_next   = held_green;
    image_width_next  = image_width;
    image_height_next = image_height;
    cur_col_next      = cur_col;
    cur_row_next      = cur_row;
    push              = 1'b0;
    result            = '0;
    result.bad_char   = evt.err;
    if (accept) begin
      if (item.start_req) begin
        phase_next        = PH_MAGIC1;
        component_next    = 2'd0;
        held_red_next     = '0;
        held_green_next   = '0;
        image_width_next  = '0;
        image_height_next = '0;
        cur_col_next      = '0;
        cur_row_next      = '0;
      end else begin
        case (phase)
          PH_MAGIC0: phase_next = PH_MAGIC1;
          PH_MAGIC1: phase_next = PH_WIDTH;
          PH_WIDTH: begin
            if (evt.done) begin
              image_width_next = value;
              phase_next       = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            if (evt.done) begin
              image_height_next = value;
              phase_next        = PH_MAXCOL;
            end
          end
          PH_MAXCOL: begin
            if (evt.done) begin
              push         = 1'b1;
              result.kind  = KIND_HEADER;
              result.col   = fit16(image_width);
              result.row   = fit16(image_height);
              result.red   = fit16(value);
              result.last  = empty_img;
              phase_next   = empty_img ? PH_DONE : PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            if (evt.done) begin
              case (component)
                2'd0: begin
                  held_red_next  = value;
                  component_next = 2'd1;
                end
                2'd1: begin
                  held_green_next = value;
                  component_next  = 2'd2;
                end
                default: begin
                  component_next = 2'd0;
                  push           = 1'b1;
                  result.kind    = KIND_PIXEL;
                  result.col     = fit16(cur_col);
                  result.row     = fit16(cur_row);
                  result.red     = fit16(held_red);
                  result.green   = fit16(held_green);
                  result.blue    = fit16(value);
                  result.last    = col_end && row_end;
                  if (col_end && row_end) begin
                    phase_next = PH_DONE;
                  end else if (col_end) begin
                    cur_col_next = '0;
                    cur_row_next = row_p1[VALUE_BITS-1:0];
                  end else begin
                    cur_col_next = col_p1[VALUE_BITS-1:0];
                  end
                end
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC0;
      component    <= 2'd0;
      held_red     <= '0;
      held_green   <= '0;
      image_width  <= '0;
      image_height <= '0;
      cur_col      <= '0;
      cur_row      <= '0;
    end else begin
      phase        <= phase_next;
      component    <= component_next;
      held_red     <= held_red_next;
      held_green   <= held_green_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      cur_col      <= cur_col_next;
      cur_row      <= cur_row_next;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) component != 2'd3)
    else $error("component counter out of range");
  // a result marked last ends the image
  assert property (@(posedge clk) disable iff (rst) push && result.last |=> phase == PH_DONE)
    else $error("last result did not end parsing");
`endif

endmodule

/* hdl/ppmsp_obuf.sv */
module ppmsp_obuf import ppmsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_item_t push_data,
  output logic         full,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  logic         head_valid;
  result_item_t head_data;
  logic         skid_valid;
  result_item_t skid_data;
  logic         pop;

  assign pop          = head_valid && !result_stall;
  assign full         = skid_valid;
  assign result_valid = head_valid;
  assign result_item  = head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          head_data  <= skid_data;
          skid_valid <= push;
          if (push) begin
            skid_data <= push_data;
          end
        end else begin
          head_valid <= push;
          if (push) begin
            head_data <= push_data;
          end
        end
      end else if (push) begin
        if (!head_valid) begin
          head_valid <= 1'b1;
          head_data  <= push_data;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= push_data;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> head_valid)
    else $error("skid entry without head entry");
  assert property (@(posedge clk) disable iff (rst) push |-> !skid_valid)
    else $error("push into full buffer");
  assert property (@(posedge clk) disable iff (rst)
    pop && !skid_valid && !push |=> !head_valid)
    else $error("buffer not emptied after last transaction");
`endif

endmodule

/* hdl/ascii_ppm_stream_parser_core.sv */
// a result is written into the output buffer when the separator byte that completes it is accepted
// throughput: one byte per cycle while byte_stall is low; tokenizer and sequencer update together on each accepted byte
// a two-entry output buffer keeps bytes flowing while a result waits
// byte_stall rises only when both buffer entries hold results
// synchronous reset clears all parse state (expects first magic byte) and empties the buffer
module ascii_ppm_stream_parser_core import ppmsp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  logic                  accept;
  tok_ctl_t              ctl;
  tok_evt_t              evt;
  logic [VALUE_BITS-1:0] value;
  logic                  push;
  result_item_t          push_data;
  logic                  full;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  ppmsp_tok #(.VALUE_BITS(VALUE_BITS)) u_tok (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .data_byte (byte_item.data_byte),
    .evt       (evt),
    .value     (value)
  );

  ppmsp_seq #(.VALUE_BITS(VALUE_BITS)) u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .evt    (evt),
    .value  (value),
    .ctl    (ctl),
    .push   (push),
    .result (push_data)
  );

  ppmsp_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
